// ===== src/aes_pkg.sv =====
// Package for the AES block cipher unit: types, constants and byte-level functions.
package aes_pkg;

	localparam int unsigned MaxRounds = 14;
	localparam int unsigned KeyRegs   = 5;

	typedef logic [3:0]   round_idx_t;
	typedef logic [127:0] block_t;
	typedef logic [7:0]   byte_t;

	// key length codes
	typedef enum logic [1:0] {
		KEY_128 = 2'd0,
		KEY_192 = 2'd1,
		KEY_256 = 2'd2
	} key_len_t;

	// register indexes
	localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
	localparam logic [2:0] REG_KEY_01     = 3'd1;
	localparam logic [2:0] REG_KEY_23     = 3'd2;
	localparam logic [2:0] REG_KEY_45     = 3'd3;
	localparam logic [2:0] REG_KEY_67     = 3'd4;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	localparam byte_t SBOX [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

	localparam byte_t INV_SBOX [256] = '{
		8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
		8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
		8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
		8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
		8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
		8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
		8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
		8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
		8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
		8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
		8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
		8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
		8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
		8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
		8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};

	// multiply by x in GF(2^8)
	function automatic byte_t xtime(input byte_t b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// forward column mix
	function automatic logic [31:0] mix_col(input logic [31:0] c);
		byte_t a0, a1, a2, a3;
		a0 = c[31:24];
		a1 = c[23:16];
		a2 = c[15:8];
		a3 = c[7:0];
		mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
			xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
	endfunction

	// inverse column mix: pre-multiply by {04}x^2+{05} then forward mix
	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		byte_t a0, a1, a2, a3, u, v;
		a0 = c[31:24];
		a1 = c[23:16];
		a2 = c[15:8];
		a3 = c[7:0];
		u = xtime(xtime(a0 ^ a2));
		v = xtime(xtime(a1 ^ a3));
		inv_mix_col = mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
	endfunction

	function automatic block_t mix_all(input block_t s, input logic inv);
		for (int c = 0; c < 4; c++) begin
			mix_all[127-32*c -: 32] = inv ? inv_mix_col(s[127-32*c -: 32])
				: mix_col(s[127-32*c -: 32]);
		end
	endfunction

	// byte substitution with row shift; byte r+4c sits at bits 127-8*(r+4c)
	function automatic block_t sub_shift(input block_t s, input logic inv);
		int src;
		byte_t v;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
				v = s[127-8*(r+4*src) -: 8];
				sub_shift[127-8*(r+4*c) -: 8] = inv ? INV_SBOX[v] : SBOX[v];
			end
		end
	endfunction

endpackage

// ===== src/aes_block_cipher_unit.sv =====
// AES block cipher unit: configuration, round sequencer and shared round logic.
// Rounds: nr = 10, 12 or 14; one request at a time, in_stall is high until the result is loaded.
// The first request after reset or a key length or key register write first runs key expansion.
// The result waits in an output register; the next request is taken meanwhile.
// Reset (arst_n, asynchronous, active low) clears control state and key registers.
module aes_block_cipher_unit
	import aes_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [63:0] block_hi,
	input  logic [63:0] block_lo,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_hi,
	output logic [63:0] result_lo
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_KEYS  = 5'b00010,
		ST_FETCH = 5'b00100,
		ST_ROUND = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t      state_q;
	logic [1:0]  key_len_q;
	logic [255:0] key_q;
	logic        keys_ready_q;
	logic        op_q;
	block_t      s_q;
	block_t      result_q;
	round_idx_t  r_q;
	round_idx_t  nr;
	logic        kx_busy, kx_done;
	block_t      rk;
	logic        out_valid_q;
	logic        res_load;

	assign nr = (key_len_q == KEY_128) ? 4'd10 : (key_len_q == KEY_192) ? 4'd12 : 4'd14;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= '0;
			key_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_LENGTH: key_len_q <= cfg_data[1:0];
				REG_KEY_01:     key_q[255:192] <= cfg_data;
				REG_KEY_23:     key_q[191:128] <= cfg_data;
				REG_KEY_45:     key_q[127:64]  <= cfg_data;
				REG_KEY_67:     key_q[63:0]    <= cfg_data;
				default: ;
			endcase
		end
	end

	aes_key_expand u_kx (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_KEYS && !kx_busy && !kx_done),
		.key_len (key_len_q),
		.key     (key_q),
		.busy    (kx_busy),
		.done    (kx_done),
		.rd_idx  (r_q),
		.rd_inv  (op_q),
		.rd_key  (rk)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign res_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// key stores valid flag: dropped by any key length or key register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_ready_q <= 1'b0;
		end else if (cfg_we && cfg_index <= REG_KEY_67) begin
			keys_ready_q <= 1'b0;
		end else if (state_q == ST_KEYS && kx_done) begin
			keys_ready_q <= 1'b1;
		end
	end

	// output register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_load || (out_valid_q && out_stall);
		end
	end

	// round sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						r_q     <= '0;
						state_q <= keys_ready_q ? ST_FETCH : ST_KEYS;
					end
				end
				ST_KEYS: begin
					if (kx_done) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					r_q     <= r_q + 4'd1;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (r_q == nr + 4'd1) begin
						state_q <= ST_DONE;
					end else begin
						r_q <= r_q + 4'd1;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// shared round datapath: the key for round r_q-1 is read through a register, addressed in the cycle before
	block_t  rnd;
	round_idx_t r_cur;
	assign r_cur = r_q - 4'd1;
	always_comb begin
		if (r_cur == 4'd0) begin
			rnd = s_q ^ rk;
		end else if (r_cur == nr) begin
			rnd = sub_shift(s_q, op_q) ^ rk;
		end else begin
			rnd = mix_all(sub_shift(s_q, op_q), op_q) ^ rk;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && !in_stall) begin
			op_q <= op;
			s_q  <= {block_hi, block_lo};
		end else if (state_q == ST_ROUND) begin
			s_q <= rnd;
		end
	end

	// result held until the receiver takes it
	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q <= s_q;
		end
	end

	assign result_hi = result_q[127:64];
	assign result_lo = result_q[63:0];

endmodule

// ===== src/aes_key_expand.sv =====
// Key schedule: four words a cycle when no round key is being stored; fills both key stores.
module aes_key_expand
	import aes_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [1:0]   key_len,
	input  logic [255:0] key,
	output logic         busy,
	output logic         done,
	input  round_idx_t   rd_idx,
	input  logic         rd_inv,
	output block_t       rd_key
);

	typedef enum logic [2:0] {
		KX_IDLE = 3'b001,
		KX_GEN  = 3'b010,
		KX_INV  = 3'b100
	} kx_state_t;

	kx_state_t   state_q;
	logic [255:0] win_q;      // last eight schedule words, newest in low bits
	logic [5:0]  word_q;      // index of next word to generate
	logic [3:0]  mod_q;       // word_q modulo the key length in words
	byte_t       rcon_q;
	round_idx_t  rk_q;        // round key being written / copied
	round_idx_t  nr;
	logic [3:0]  nk;
	logic [5:0]  total;
	logic [5:0]  kw_pos;
	block_t      rk_mem [MaxRounds+1];
	block_t      ik_mem [MaxRounds+1];
	block_t      cp_rd;

	assign nr    = (key_len == KEY_128) ? 4'd10 : (key_len == KEY_192) ? 4'd12 : 4'd14;
	assign nk    = nr - 4'd6;
	assign total = {nr, 2'b00} + 6'd4;
	assign busy  = (state_q != KX_IDLE);
	assign kw_pos = {rk_q, 2'b00};

	// key words placed newest-low: word 0 oldest
	logic [255:0] win_init;
	always_comb begin
		win_init = '0;
		for (int i = 0; i < 8; i++) begin
			if (i < nk) begin
				win_init[32*(nk-1-i) +: 32] = key[255-32*i -: 32];
			end
		end
	end

	// four schedule words; at most one of them needs the S-box (for nk = 8, word_q is a multiple of four)
	logic [255:0] win_n;
	byte_t        rcon_n;
	logic [3:0]   mod;
	logic [3:0]   mod_n;
	logic [31:0]  t;
	logic [31:0]  wprev;
	logic [31:0]  wold;
	always_comb begin
		win_n  = win_q;
		rcon_n = rcon_q;
		mod    = mod_q;
		t      = '0;
		wprev  = '0;
		wold   = '0;
		for (int k = 0; k < 4; k++) begin
			wprev = win_n[31:0];
			wold  = win_n[32*nk-1 -: 32];
			t = wprev;
			if (mod == 4'd0) begin
				t = sub_word({wprev[23:0], wprev[31:24]}) ^ {rcon_n, 24'h0};
				rcon_n = xtime(rcon_n);
			end else if (nk == 4'd8 && mod == 4'd4) begin
				t = sub_word(wprev);
			end
			win_n = {win_n[223:0], wold ^ t};
			mod = (mod == nk - 4'd1) ? 4'd0 : mod + 4'd1;
		end
		mod_n = mod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KX_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				KX_IDLE: begin
					if (start) begin
						state_q <= KX_GEN;
					end
				end
				KX_GEN: begin
					if (rk_q == nr && kw_pos + 6'd4 <= word_q) begin
						state_q <= KX_INV;
					end
				end
				KX_INV: begin
					if (rk_q == nr) begin
						state_q <= KX_IDLE;
						done    <= 1'b1;
					end
				end
				default: state_q <= KX_IDLE;
			endcase
		end
	end

	// schedule window and counters
	always_ff @(posedge clk) begin
		case (state_q)
			KX_IDLE: begin
				win_q  <= win_init;
				word_q <= {2'b0, nk};
				mod_q  <= '0;
				rcon_q <= 8'h01;
				rk_q   <= '0;
			end
			KX_GEN: begin
				// round key rk_q is words 4rk..4rk+3; store it once they exist
				if (kw_pos + 6'd4 <= word_q) begin
					rk_mem[rk_q] <= win_q[32*(word_q-kw_pos)-1 -: 128];
					rk_q <= (rk_q == nr) ? '0 : rk_q + 4'd1;
				end else begin
					win_q  <= win_n;
					word_q <= word_q + 6'd4;
					mod_q  <= mod_n;
					rcon_q <= rcon_n;
				end
			end
			KX_INV: begin
				rk_q <= rk_q + 4'd1;
			end
			default: ;
		endcase
	end

	// inverse keys: copy reversed, middle ones through inverse mix
	block_t cp_key;
	assign cp_key = rk_mem[nr - rk_q];
	always_ff @(posedge clk) begin
		if (state_q == KX_INV) begin
			ik_mem[rk_q] <= (rk_q == 4'd0 || rk_q == nr) ? cp_key : mix_all(cp_key, 1'b1);
		end
		cp_rd <= rd_inv ? ik_mem[rd_idx] : rk_mem[rd_idx];
	end
	assign rd_key = cp_rd;

endmodule
